[rtl/sspr_pkg.sv]
// Shared widths, constants, codes and types of the stepper speed ramp.
package sspr_pkg;

  localparam int SPEED_W  = 32;
  localparam int CFG_W    = 31;
  localparam int RATE_W   = 24;
  localparam int PERIOD_W = 24;
  localparam int FRAC_W   = 16;
  localparam int DVD_W    = RATE_W + FRAC_W;
  localparam int DVS_W    = SPEED_W;
  localparam int CNT_W    = $clog2(DVD_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] ZERO_SPEED_PERIOD = 24'd100000;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD        = 24'd10000000;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_RATE = 2'd2;

  localparam logic [CFG_W-1:0]  MAX_SPEED_RESET  = 31'd65536000;
  localparam logic [CFG_W-1:0]  ACCEL_RESET      = 31'd65536;
  localparam logic [RATE_W-1:0] TIMER_RATE_RESET = 24'd1000000;

  localparam logic FUNC_SET_TARGET = 1'b0;
  localparam logic FUNC_TICK       = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

[rtl/sspr_channels.sv]
// Handshake channels for command beats into and result beats out of the ramp.
interface sspr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [sspr_pkg::SPEED_W-1:0] target_speed;

  modport source(output valid, func, target_speed, input ready);
  modport sink(input valid, func, target_speed, output ready);
endinterface

interface sspr_res_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sspr_pkg::PERIOD_W-1:0] step_period;
  logic                                 direction;
  logic                                 timer_write;
  logic                                 speed_applied;
  logic signed [sspr_pkg::SPEED_W-1:0]  ramp_speed;

  modport source(output valid, step_period, direction, timer_write, speed_applied,
                 ramp_speed, input ready);
  modport sink(input valid, step_period, direction, timer_write, speed_applied,
               ramp_speed, output ready);
endinterface

[rtl/sspr_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module sspr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  sspr_pkg::div_req_t           req,
  output logic                         done,
  output logic [sspr_pkg::DVD_W-1:0]   quotient
);

  logic                         busy;
  logic [sspr_pkg::CNT_W-1:0]   cnt;
  logic [sspr_pkg::DVD_W-1:0]   work;
  logic [sspr_pkg::DVS_W-1:0]   rem;
  logic [sspr_pkg::DVS_W-1:0]   dvs;
  logic [sspr_pkg::DVS_W:0]     rem_sh;
  logic [sspr_pkg::DVS_W:0]     diff;
  logic                         ge;
  logic [sspr_pkg::DVS_W-1:0]   rem_next;

  always_comb begin
    rem_sh   = {rem, work[sspr_pkg::DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? diff[sspr_pkg::DVS_W-1:0] : rem_sh[sspr_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sspr_pkg::CNT_W'(sspr_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      work <= {work[sspr_pkg::DVD_W-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

[rtl/stepper_speed_ramp_period.sv]
// Stepper speed ramp for one axis with step-period generation. A set-target beat or a
// tick that finds the speed already at its target goes to the push state, which loads
// its result beat into the output register once that register is free. A tick that moves
// the speed first passes the load state, which forms the magnitude of the stepped speed and
// starts the restoring divider, then the divide state, in which the divider forms
// timer_rate*65536/|speed| one quotient bit per cycle and the saturated quotient is taken,
// then the push state; a tick that lands on zero speed skips the divider. The block takes
// one command beat at a time and accepts a new one as soon as the previous result sits in
// the output register, even if that result has not yet been taken.
module stepper_speed_ramp_period (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sspr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sspr_pkg::CFG_W-1:0]         cfg_data,
  sspr_cmd_if.sink                           cmd,
  sspr_res_if.source                         res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]                           state;
  logic [sspr_pkg::CFG_W-1:0]           max_speed;
  logic [sspr_pkg::CFG_W-1:0]           accel;
  logic [sspr_pkg::RATE_W-1:0]          timer_rate;
  logic signed [sspr_pkg::SPEED_W-1:0]  speed_now;
  logic signed [sspr_pkg::SPEED_W-1:0]  speed_goal;
  logic [sspr_pkg::PERIOD_W-1:0]        last_period;
  logic                                 last_direction;
  logic                                 twrite;
  logic                                 applied;

  logic                                 res_valid;
  logic [sspr_pkg::PERIOD_W-1:0]        res_period;
  logic                                 res_dir;
  logic                                 res_tw;
  logic                                 res_app;
  logic signed [sspr_pkg::SPEED_W-1:0]  res_speed;

  logic                                 accept;
  logic                                 slot_free;
  logic signed [sspr_pkg::SPEED_W:0]    t33;
  logic signed [sspr_pkg::SPEED_W:0]    max33;
  logic signed [sspr_pkg::SPEED_W:0]    nmax33;
  logic signed [sspr_pkg::SPEED_W-1:0]  goal_clamped;
  logic signed [sspr_pkg::SPEED_W:0]    now33;
  logic signed [sspr_pkg::SPEED_W:0]    goal33;
  logic signed [sspr_pkg::SPEED_W:0]    acc33;
  logic signed [sspr_pkg::SPEED_W:0]    up;
  logic signed [sspr_pkg::SPEED_W:0]    dn;
  logic signed [sspr_pkg::SPEED_W-1:0]  speed_step;
  logic                                 at_goal;
  logic [sspr_pkg::DVS_W-1:0]           speed_mag;
  logic                                 speed_zero;
  sspr_pkg::div_req_t                   div_req;
  logic                                 div_done;
  logic [sspr_pkg::DVD_W-1:0]           div_quot;
  logic [sspr_pkg::PERIOD_W-1:0]        period_sat;
  logic [sspr_pkg::PERIOD_W-1:0]        period_cand;
  logic                                 finalize;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign slot_free = !res_valid || res.ready;

  always_comb begin
    t33    = {cmd.target_speed[sspr_pkg::SPEED_W-1], cmd.target_speed};
    max33  = {2'b00, max_speed};
    nmax33 = -max33;
    if (t33 > max33) begin
      goal_clamped = max33[sspr_pkg::SPEED_W-1:0];
    end else if (t33 < nmax33) begin
      goal_clamped = nmax33[sspr_pkg::SPEED_W-1:0];
    end else begin
      goal_clamped = cmd.target_speed;
    end
  end

  always_comb begin
    now33   = {speed_now[sspr_pkg::SPEED_W-1], speed_now};
    goal33  = {speed_goal[sspr_pkg::SPEED_W-1], speed_goal};
    acc33   = {2'b00, accel};
    up      = now33 + acc33;
    dn      = now33 - acc33;
    at_goal = (speed_now == speed_goal);
    if (speed_goal > speed_now) begin
      speed_step = (up > goal33) ? speed_goal : up[sspr_pkg::SPEED_W-1:0];
    end else begin
      speed_step = (dn < goal33) ? speed_goal : dn[sspr_pkg::SPEED_W-1:0];
    end
  end

  always_comb begin
    speed_zero = (speed_now == '0);
    speed_mag  = speed_now[sspr_pkg::SPEED_W-1] ? sspr_pkg::DVS_W'(-speed_now)
                                                : sspr_pkg::DVS_W'(speed_now);
    div_req.start    = (state == ST_LOAD) && !speed_zero;
    div_req.dividend = {timer_rate, sspr_pkg::FRAC_W'(0)};
    div_req.divisor  = speed_mag;
  end

  sspr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    period_sat  = (div_quot > sspr_pkg::DVD_W'(sspr_pkg::MAX_PERIOD))
                  ? sspr_pkg::MAX_PERIOD : div_quot[sspr_pkg::PERIOD_W-1:0];
    period_cand = (state == ST_LOAD) ? sspr_pkg::ZERO_SPEED_PERIOD : period_sat;
    finalize    = ((state == ST_LOAD) && speed_zero) || div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= sspr_pkg::MAX_SPEED_RESET;
      accel      <= sspr_pkg::ACCEL_RESET;
      timer_rate <= sspr_pkg::TIMER_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sspr_pkg::REG_MAX_SPEED:  max_speed  <= cfg_data;
        sspr_pkg::REG_ACCEL:      accel      <= cfg_data;
        sspr_pkg::REG_TIMER_RATE: timer_rate <= cfg_data[sspr_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      speed_now      <= '0;
      speed_goal     <= '0;
      last_period    <= '0;
      last_direction <= 1'b0;
      twrite         <= 1'b0;
      applied        <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if ((state == ST_PUSH) && slot_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            twrite  <= 1'b0;
            applied <= 1'b0;
            if (cmd.func == sspr_pkg::FUNC_SET_TARGET) begin
              speed_goal <= goal_clamped;
              state      <= ST_PUSH;
            end else if (at_goal) begin
              state <= ST_PUSH;
            end else begin
              speed_now <= speed_step;
              applied   <= 1'b1;
              state     <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          state <= speed_zero ? ST_PUSH : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finalize) begin
        last_direction <= !(speed_now > 0);
        last_period    <= period_cand;
        twrite         <= (period_cand != last_period);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_PUSH) && slot_free) begin
      res_period <= last_period;
      res_dir    <= last_direction;
      res_tw     <= twrite;
      res_app    <= applied;
      res_speed  <= speed_now;
    end
  end

  assign res.valid         = res_valid;
  assign res.step_period   = res_period;
  assign res.direction     = res_dir;
  assign res.timer_write   = res_tw;
  assign res.speed_applied = res_app;
  assign res.ramp_speed    = res_speed;

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("Divider finished outside the divide state.");

  a_res_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_PUSH)
    else $error("Result beat appeared without passing the push state.");

  a_write_applied: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.timer_write |-> res.speed_applied)
    else $error("Timer write flagged on a beat that did not apply a speed change.");

  a_period_sat: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.step_period <= sspr_pkg::MAX_PERIOD)
    else $error("Step period exceeds its saturation limit.");

endmodule
